// ===== design/owm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and register codes of the one-wire bus master.
package owm_pkg;

   // Width of every timing register.
   localparam int CFG_W = 12;
   // Default width of the phase timer.
   localparam int OWM_TIMER_BITS = 12;
   // Number of timing registers and width of their index.
   localparam int CFG_COUNT = 8;
   localparam int CFG_IDX_W = 3;

   // Byte width of the data shifted over the bus.
   localparam int BYTE_W = 8;

   // Register indexes on the configuration port.
   localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
   localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
   localparam logic [CFG_IDX_W-1:0] REG_RESET_RECOV   = 3'd2;
   localparam logic [CFG_IDX_W-1:0] REG_SHORT_LOW     = 3'd3;
   localparam logic [CFG_IDX_W-1:0] REG_LONG_LOW      = 3'd4;
   localparam logic [CFG_IDX_W-1:0] REG_ZERO_RECOV    = 3'd5;
   localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE   = 3'd6;
   localparam logic [CFG_IDX_W-1:0] REG_READ_RECOV    = 3'd7;

   // Reset values of the timing registers, in ticks.
   localparam logic [CFG_W-1:0] RST_RESET_LOW     = 12'd2000;
   localparam logic [CFG_W-1:0] RST_PRESENCE_WAIT = 12'd70;
   localparam logic [CFG_W-1:0] RST_RESET_RECOV   = 12'd500;
   localparam logic [CFG_W-1:0] RST_SHORT_LOW     = 12'd5;
   localparam logic [CFG_W-1:0] RST_LONG_LOW      = 12'd70;
   localparam logic [CFG_W-1:0] RST_ZERO_RECOV    = 12'd5;
   localparam logic [CFG_W-1:0] RST_READ_SAMPLE   = 12'd10;
   localparam logic [CFG_W-1:0] RST_READ_RECOV    = 12'd60;

   // Bus commands.
   localparam logic [1:0] CMD_RESET = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   // All timing registers, handed to the phase engine as one group.
   typedef struct packed {
      logic [CFG_W-1:0] reset_low;
      logic [CFG_W-1:0] presence_wait;
      logic [CFG_W-1:0] reset_recov;
      logic [CFG_W-1:0] short_low;
      logic [CFG_W-1:0] long_low;
      logic [CFG_W-1:0] zero_recov;
      logic [CFG_W-1:0] read_sample;
      logic [CFG_W-1:0] read_recov;
   } cfg_type;

   // One tick request as seen by the phase engine.
   typedef struct packed {
      logic              command_valid;
      logic [1:0]        command;
      logic [BYTE_W-1:0] write_data;
      logic              line_level;
   } tick_type;

   // One tick result.
   typedef struct packed {
      logic [BYTE_W-1:0] read_data;
      logic              presence;
      logic              done_res;
      logic              busy_res;
      logic              line_release;
   } result_type;

endpackage

// ===== design/onewire_bus_master_top.sv =====
`timescale 1ns / 1ps
// Top level of the one-wire bus master: stream ports, timing registers, pipeline.
//
// Each request on the req_ channel is one tick of about one microsecond. It
// carries the sampled bus level and an optional command (bus reset, write
// byte, read byte); a command is taken only while no operation runs.
// Every request yields exactly one response on the rsp_ channel with the
// open-drain release level, busy, a one-tick done pulse, the presence flag
// and the last byte read.
// Timing registers are written through csr_we / csr_index / csr_wdata and
// should only change while the master is idle.
// A request passes through the input register and one tick of combinational
// phase logic into the response register. Throughput is one request per
// cycle while the receiver does not stall, set by the combinational phase update.
// When the receiver stalls, the response register holds and the input
// register fills; req_tready drops only when both are full.
// A synchronous reset empties both registers, puts the phase engine in its
// idle phase and loads the default timing values.
module onewire_bus_master_top
   import owm_pkg::*;
#(
   parameter int TIMER_BITS = OWM_TIMER_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   // Request channel.
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [15:0]          req_tdata,  // write_data[7:0], line_level[8], zeros
   input  logic [2:0]           req_tuser,  // command_valid[0], command[2:1]
   // Response channel.
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [15:0]          rsp_tdata,  // line_release[0], busy_res[1],
                                            // done_res[2], presence[3], read_data[11:4]
   // Configuration port.
   input  logic                 csr_we,
   input  logic [CFG_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   logic       in_valid_ff;
   tick_type   in_tick_ff;
   logic       out_valid_ff;
   result_type out_result_ff;
   cfg_type    cfg_ff, cfg_in;
   result_type result;
   logic       advance;

   // A request in the input register moves on when the response slot frees.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_tick_ff.command_valid <= req_tuser[0];
         in_tick_ff.command       <= req_tuser[2:1];
         in_tick_ff.write_data    <= req_tdata[7:0];
         in_tick_ff.line_level    <= req_tdata[8];
      end
   end

   // Timing register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_RESET_LOW:     cfg_in.reset_low     = csr_wdata;
            REG_PRESENCE_WAIT: cfg_in.presence_wait = csr_wdata;
            REG_RESET_RECOV:   cfg_in.reset_recov   = csr_wdata;
            REG_SHORT_LOW:     cfg_in.short_low     = csr_wdata;
            REG_LONG_LOW:      cfg_in.long_low      = csr_wdata;
            REG_ZERO_RECOV:    cfg_in.zero_recov    = csr_wdata;
            REG_READ_SAMPLE:   cfg_in.read_sample   = csr_wdata;
            REG_READ_RECOV:    cfg_in.read_recov    = csr_wdata;
            default:           cfg_in               = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low     <= RST_RESET_LOW;
         cfg_ff.presence_wait <= RST_PRESENCE_WAIT;
         cfg_ff.reset_recov   <= RST_RESET_RECOV;
         cfg_ff.short_low     <= RST_SHORT_LOW;
         cfg_ff.long_low      <= RST_LONG_LOW;
         cfg_ff.zero_recov    <= RST_ZERO_RECOV;
         cfg_ff.read_sample   <= RST_READ_SAMPLE;
         cfg_ff.read_recov    <= RST_READ_RECOV;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Phase engine runs one tick per advancing request.
   owm_engine #(
      .TIMER_BITS (TIMER_BITS)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .cfg    (cfg_ff),
      .tick   (in_tick_ff),
      .result (result)
   );

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_result_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, out_result_ff.read_data, out_result_ff.presence,
                        out_result_ff.done_res, out_result_ff.busy_res,
                        out_result_ff.line_release};

   // A finishing tick never reports the master as still busy.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> !rsp_tdata[1])
      else $error("done and busy both set in one response");

   // A processed request always shows up in the response register next cycle.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("processed request produced no response");

   // An idle tick leaves the bus released.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[1] && !rsp_tdata[2] |-> rsp_tdata[0])
      else $error("bus driven low while idle");

endmodule

// ===== design/owm_engine.sv =====
`timescale 1ns / 1ps
// Phase engine of the one-wire bus master: state registers and one tick of work.
module owm_engine
   import owm_pkg::*;
#(
   parameter int TIMER_BITS = OWM_TIMER_BITS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  cfg_type    cfg,
   input  tick_type   tick,
   output result_type result
);

   typedef enum logic [9:0] {
      PH_IDLE     = 10'b00_0000_0001,
      PH_RST_PRE  = 10'b00_0000_0010,
      PH_RST_LOW  = 10'b00_0000_0100,
      PH_RST_WAIT = 10'b00_0000_1000,
      PH_RST_REC  = 10'b00_0001_0000,
      PH_WR_LOW   = 10'b00_0010_0000,
      PH_WR_REL   = 10'b00_0100_0000,
      PH_RD_LOW   = 10'b00_1000_0000,
      PH_RD_WAIT  = 10'b01_0000_0000,
      PH_RD_REC   = 10'b10_0000_0000
   } phase_type;

   // Compare width wide enough for both a register value and the timer limit.
   localparam int CW = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
   localparam logic [CW-1:0] TMAX = CW'((1 << TIMER_BITS) - 1);
   localparam logic [2:0] LAST_BIT = 3'd7;

   phase_type              phase_ff, phase_in;
   logic [TIMER_BITS-1:0]  timer_ff, timer_in;
   logic [2:0]             bit_ff, bit_in;
   logic [BYTE_W-1:0]      shift_ff, shift_in;
   logic                   presence_ff, presence_in;
   logic [BYTE_W-1:0]      rdata_ff, rdata_in;
   logic                   release_c, done_c;

   // A zero count acts as one tick; a count beyond the timer saturates.
   function automatic logic [TIMER_BITS-1:0] sat_len(input logic [CFG_W-1:0] v);
      logic [CW-1:0] w;
      w = CW'(v);
      if (w == '0) w = CW'(1);
      if (w > TMAX) w = TMAX;
      return TIMER_BITS'(w);
   endfunction

   // One tick: take a command when idle, then run the current phase.
   always_comb begin
      phase_in    = phase_ff;
      timer_in    = timer_ff;
      bit_in      = bit_ff;
      shift_in    = shift_ff;
      presence_in = presence_ff;
      rdata_in    = rdata_ff;
      release_c   = 1'b1;
      done_c      = 1'b0;

      if (phase_ff == PH_IDLE && tick.command_valid) begin
         unique case (tick.command)
            CMD_RESET: begin
               bit_in   = '0;
               shift_in = '0;
               phase_in = PH_RST_PRE;
               timer_in = sat_len(cfg.short_low);
            end
            CMD_WRITE: begin
               bit_in   = '0;
               shift_in = tick.write_data;
               phase_in = PH_WR_LOW;
               timer_in = sat_len(tick.write_data[0] ? cfg.short_low : cfg.long_low);
            end
            CMD_READ: begin
               bit_in   = '0;
               shift_in = '0;
               phase_in = PH_RD_LOW;
               timer_in = sat_len(cfg.short_low);
            end
            default: begin
               // Unknown command is ignored.
            end
         endcase
      end

      if (phase_in != PH_IDLE) begin
         release_c = !(phase_in == PH_RST_LOW || phase_in == PH_WR_LOW ||
                       phase_in == PH_RD_LOW);
         if (timer_in > TIMER_BITS'(1)) begin
            timer_in = timer_in - TIMER_BITS'(1);
         end else begin
            unique case (phase_in)
               PH_RST_PRE: begin
                  phase_in = PH_RST_LOW;
                  timer_in = sat_len(cfg.reset_low);
               end
               PH_RST_LOW: begin
                  phase_in = PH_RST_WAIT;
                  timer_in = sat_len(cfg.presence_wait);
               end
               PH_RST_WAIT: begin
                  presence_in = !tick.line_level;
                  phase_in    = PH_RST_REC;
                  timer_in    = sat_len(cfg.reset_recov);
               end
               PH_RST_REC: begin
                  done_c = 1'b1;
               end
               PH_WR_LOW: begin
                  phase_in = PH_WR_REL;
                  timer_in = sat_len(shift_in[0] ? cfg.long_low : cfg.zero_recov);
               end
               PH_WR_REL: begin
                  shift_in = {1'b0, shift_in[BYTE_W-1:1]};
                  if (bit_in == LAST_BIT) begin
                     done_c = 1'b1;
                  end else begin
                     bit_in   = bit_in + 3'd1;
                     phase_in = PH_WR_LOW;
                     timer_in = sat_len(shift_in[0] ? cfg.short_low : cfg.long_low);
                  end
               end
               PH_RD_LOW: begin
                  phase_in = PH_RD_WAIT;
                  timer_in = sat_len(cfg.read_sample);
               end
               PH_RD_WAIT: begin
                  shift_in = {tick.line_level, shift_in[BYTE_W-1:1]};
                  phase_in = PH_RD_REC;
                  timer_in = sat_len(cfg.read_recov);
               end
               PH_RD_REC: begin
                  if (bit_in == LAST_BIT) begin
                     rdata_in = shift_in;
                     done_c   = 1'b1;
                  end else begin
                     bit_in   = bit_in + 3'd1;
                     phase_in = PH_RD_LOW;
                     timer_in = sat_len(cfg.short_low);
                  end
               end
               default: begin
                  done_c = 1'b1;
               end
            endcase
            if (done_c) begin
               phase_in = PH_IDLE;
               timer_in = '0;
            end
         end
      end
   end

   // Result fields of this tick.
   always_comb begin
      result.line_release = release_c;
      result.busy_res     = (phase_in != PH_IDLE);
      result.done_res     = done_c;
      result.presence     = presence_in;
      result.read_data    = rdata_in;
   end

   // State advances only on ticks that are actually processed.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         timer_ff    <= '0;
         bit_ff      <= '0;
         shift_ff    <= '0;
         presence_ff <= 1'b0;
         rdata_ff    <= '0;
      end else if (step) begin
         phase_ff    <= phase_in;
         timer_ff    <= timer_in;
         bit_ff      <= bit_in;
         shift_ff    <= shift_in;
         presence_ff <= presence_in;
         rdata_ff    <= rdata_in;
      end
   end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the one-wire bus master: tick stream, timing registers, checks.
module testbench;
   import owm_pkg::*;

   // The command code that the master must ignore.
   localparam logic [1:0] CMD_UNDEF = 2'd3;
   localparam int unsigned TIMER_MAX = (1 << OWM_TIMER_BITS) - 1;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 6;
   localparam int HOLD_CYCLES = 60;

   // Responses whose values are obvious: idle line, and the end of a bus reset.
   localparam result_type RES_IDLE = '{read_data: 8'h00, presence: 1'b0, done_res: 1'b0,
                                       busy_res: 1'b0, line_release: 1'b1};
   localparam result_type RES_IDLE_P = '{read_data: 8'h00, presence: 1'b1, done_res: 1'b0,
                                         busy_res: 1'b0, line_release: 1'b1};
   localparam result_type RES_RST_DONE = '{read_data: 8'h00, presence: 1'b1, done_res: 1'b1,
                                           busy_res: 1'b0, line_release: 1'b1};

   typedef enum logic [3:0] {
      BP_IDLE, BP_RST_PRE, BP_RST_LOW, BP_RST_WAIT, BP_RST_REC,
      BP_WR_LOW, BP_WR_REL, BP_RD_LOW, BP_RD_WAIT, BP_RD_REC
   } bus_phase_type;

   typedef struct {
      logic              cv;
      logic [1:0]        cmd;
      logic [BYTE_W-1:0] wd;
      logic              line;
      int                reps;
      logic              typed;
      result_type        want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [15:0] req_tdata = '0;
   logic [2:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic [CFG_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0] csr_wdata = '0;

   // Local copy of the bus engine state and timing registers.
   bus_phase_type bus_phase = BP_IDLE;
   int unsigned phase_left = 0;
   logic [2:0] slot_idx = '0;
   logic [BYTE_W-1:0] slot_byte = '0;
   logic present_seen = 1'b0;
   logic [BYTE_W-1:0] byte_read = '0;
   logic [CFG_W-1:0] tick_cfg [CFG_COUNT];

   // Responses still owed by the master, oldest first.
   result_type rsp_owed [$];

   int sender_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_req = 1'b0;
   int hold_left = 0;
   int mismatches = 0;
   int quiet_cycles = 0;
   int tick_total = 0;
   int settings_used = 0;
   int ops_started [3] = '{0, 0, 0};

   // Eighteen rows of directed ticks, run with every register at zero (one tick per phase).
   dir_row_type dir_rows [0:17] = '{
      '{1'b0, CMD_RESET, 8'h00, 1'b1, 1, 1'b1, RES_IDLE},
      '{1'b1, CMD_UNDEF, 8'hFF, 1'b0, 1, 1'b1, RES_IDLE},
      '{1'b1, CMD_RESET, 8'h00, 1'b1, 1, 1'b0, RES_IDLE},
      '{1'b1, CMD_WRITE, 8'h5A, 1'b1, 1, 1'b0, RES_IDLE},
      '{1'b0, CMD_RESET, 8'h00, 1'b0, 1, 1'b0, RES_IDLE},
      '{1'b0, CMD_RESET, 8'h00, 1'b1, 1, 1'b1, RES_RST_DONE},
      '{1'b1, CMD_WRITE, 8'hFF, 1'b1, 1, 1'b0, RES_IDLE},
      '{1'b0, CMD_READ,  8'h00, 1'b1, 15, 1'b0, RES_IDLE},
      '{1'b1, CMD_WRITE, 8'h00, 1'b0, 1, 1'b0, RES_IDLE},
      '{1'b1, CMD_RESET, 8'hFF, 1'b0, 15, 1'b0, RES_IDLE},
      '{1'b1, CMD_READ,  8'h00, 1'b1, 1, 1'b0, RES_IDLE},
      '{1'b1, CMD_READ,  8'h00, 1'b1, 23, 1'b0, RES_IDLE},
      '{1'b1, CMD_READ,  8'hFF, 1'b0, 1, 1'b0, RES_IDLE},
      '{1'b0, CMD_READ,  8'h00, 1'b0, 23, 1'b0, RES_IDLE},
      '{1'b0, CMD_RESET, 8'h00, 1'b0, 1, 1'b1, RES_IDLE_P},
      '{1'b1, CMD_RESET, 8'h00, 1'b0, 1, 1'b0, RES_IDLE},
      '{1'b0, CMD_RESET, 8'h00, 1'b1, 3, 1'b0, RES_IDLE},
      '{1'b1, CMD_UNDEF, 8'h00, 1'b1, 1, 1'b1, RES_IDLE}
   };

   onewire_bus_master_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Start a phase with its tick count; zero counts as one, long counts saturate.
   function automatic void load_phase(bus_phase_type nxt, logic [CFG_W-1:0] len);
      int unsigned n;
      n = len;
      if (n == 0) n = 1;
      if (n > TIMER_MAX) n = TIMER_MAX;
      bus_phase = nxt;
      phase_left = n;
   endfunction

   // Move past the phase that ends on this tick; returns 1 when the whole operation ends.
   function automatic logic close_phase(logic line);
      logic ends;
      ends = 1'b0;
      case (bus_phase)
         BP_RST_PRE: load_phase(BP_RST_LOW, tick_cfg[REG_RESET_LOW]);
         BP_RST_LOW: load_phase(BP_RST_WAIT, tick_cfg[REG_PRESENCE_WAIT]);
         BP_RST_WAIT: begin
            present_seen = ~line;
            load_phase(BP_RST_REC, tick_cfg[REG_RESET_RECOV]);
         end
         BP_WR_LOW: begin
            load_phase(BP_WR_REL,
                       slot_byte[0] ? tick_cfg[REG_LONG_LOW] : tick_cfg[REG_ZERO_RECOV]);
         end
         BP_WR_REL: begin
            slot_byte = slot_byte >> 1;
            if (slot_idx == 3'd7) begin
               ends = 1'b1;
            end else begin
               slot_idx++;
               load_phase(BP_WR_LOW,
                          slot_byte[0] ? tick_cfg[REG_SHORT_LOW] : tick_cfg[REG_LONG_LOW]);
            end
         end
         BP_RD_LOW: load_phase(BP_RD_WAIT, tick_cfg[REG_READ_SAMPLE]);
         BP_RD_WAIT: begin
            slot_byte = {line, slot_byte[BYTE_W-1:1]};
            load_phase(BP_RD_REC, tick_cfg[REG_READ_RECOV]);
         end
         BP_RD_REC: begin
            if (slot_idx == 3'd7) begin
               byte_read = slot_byte;
               ends = 1'b1;
            end else begin
               slot_idx++;
               load_phase(BP_RD_LOW, tick_cfg[REG_SHORT_LOW]);
            end
         end
         default: ends = 1'b1;
      endcase
      if (ends) begin
         bus_phase = BP_IDLE;
         phase_left = 0;
      end
      return ends;
   endfunction

   // Advance the bus engine by one tick and return the response it owes.
   function automatic result_type bus_tick(logic cv, logic [1:0] cmd, logic [BYTE_W-1:0] wd,
                                           logic line);
      result_type r;
      r.line_release = 1'b1;
      r.done_res = 1'b0;
      if (bus_phase == BP_IDLE && cv && cmd != CMD_UNDEF) begin
         slot_idx = '0;
         ops_started[cmd]++;
         case (cmd)
            CMD_RESET: begin
               slot_byte = '0;
               load_phase(BP_RST_PRE, tick_cfg[REG_SHORT_LOW]);
            end
            CMD_WRITE: begin
               slot_byte = wd;
               load_phase(BP_WR_LOW, wd[0] ? tick_cfg[REG_SHORT_LOW] : tick_cfg[REG_LONG_LOW]);
            end
            default: begin
               slot_byte = '0;
               load_phase(BP_RD_LOW, tick_cfg[REG_SHORT_LOW]);
            end
         endcase
      end
      if (bus_phase != BP_IDLE) begin
         r.line_release = !(bus_phase == BP_RST_LOW || bus_phase == BP_WR_LOW ||
                            bus_phase == BP_RD_LOW);
         if (phase_left > 1) phase_left--;
         else r.done_res = close_phase(line);
      end
      r.busy_res = (bus_phase != BP_IDLE);
      r.presence = present_seen;
      r.read_data = byte_read;
      return r;
   endfunction

   // Offer one tick request, with random sender gaps, and book its response once taken.
   task automatic push_tick(input logic cv, input logic [1:0] cmd, input logic [BYTE_W-1:0] wd,
                            input logic line, input logic typed, input result_type want);
      result_type r;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'b0, line, wd};
      req_tuser <= {cmd, cv};
      do @(posedge clock); while (!req_tready);
      r = bus_tick(cv, cmd, wd, line);
      rsp_owed.push_back(typed ? want : r);
      tick_total++;
   endtask

   // Stop offering and wait until every owed response is back, plus pipeline slack.
   task automatic drain_all();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (rsp_owed.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write all eight timing registers, one per cycle; the master is idle here.
   task automatic load_timing(input logic [CFG_W-1:0] vals [CFG_COUNT]);
      for (int i = 0; i < CFG_COUNT; i++) begin
         csr_we <= 1'b1;
         csr_index <= CFG_IDX_W'(i);
         csr_wdata <= vals[i];
         tick_cfg[i] = vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // Random register set with every tick count in [lo, hi].
   task automatic load_random_timing(input int lo, input int hi);
      logic [CFG_W-1:0] vals [CFG_COUNT];
      for (int i = 0; i < CFG_COUNT; i++) vals[i] = CFG_W'($urandom_range(hi, lo));
      load_timing(vals);
   endtask

   // Random ticks until the given number of operations has started and finished.
   task automatic run_ops(input int ops, input int idle_pct, input int stall_pct,
                          input bit hold);
      int started;
      bit paused;
      logic cv;
      logic [1:0] cmd;
      int r;
      started = 0;
      paused = 1'b0;
      sender_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      if (hold) hold_req = 1'b1;
      while (started < ops || bus_phase != BP_IDLE) begin
         // Halfway through, let the master run dry before going on.
         if (!paused && started == ops / 2 && bus_phase == BP_IDLE) begin
            paused = 1'b1;
            req_tvalid <= 1'b0;
            do @(posedge clock); while (rsp_owed.size() != 0);
         end
         cmd = 2'($urandom_range(3));
         if (bus_phase == BP_IDLE) begin
            r = $urandom_range(99);
            cv = (started < ops) && (r >= 8);
            if (cv && r < 14) cmd = CMD_UNDEF;
            else if (cv) cmd = 2'($urandom_range(2));
            if (cv && cmd != CMD_UNDEF) started++;
         end else begin
            cv = ($urandom_range(9) == 0);
         end
         push_tick(cv, cmd, 8'($urandom), 1'($urandom), 1'b0, RES_IDLE);
      end
      drain_all();
   endtask

   // Receiver: random stalls, or a long hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_req) begin
         hold_left = HOLD_CYCLES;
         hold_req = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Response checker: every taken response against the oldest owed one.
   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{read_data: rsp_tdata[11:4], presence: rsp_tdata[3], done_res: rsp_tdata[2],
                 busy_res: rsp_tdata[1], line_release: rsp_tdata[0]};
         if (rsp_owed.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected response %h with none owed", rsp_tdata);
         end else begin
            want = rsp_owed.pop_front();
            if (got.line_release !== want.line_release || got.busy_res !== want.busy_res ||
                got.done_res !== want.done_res || got.presence !== want.presence ||
                got.read_data !== want.read_data) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("Mismatch: expected rel=%b busy=%b done=%b pres=%b rd=%h,",
                           want.line_release, want.busy_res, want.done_res, want.presence,
                           want.read_data);
                  $display("          got rel=%b busy=%b done=%b pres=%b rd=%h",
                           got.line_release, got.busy_res, got.done_res, got.presence,
                           got.read_data);
               end
            end
         end
      end
   end

   // Watchdog on cycles with no request or response taken.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired after %0d quiet cycles", quiet_cycles);
         $display("[onewire_bus_master_top] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [CFG_W-1:0] vals [CFG_COUNT];
      tick_cfg[REG_RESET_LOW] = RST_RESET_LOW;
      tick_cfg[REG_PRESENCE_WAIT] = RST_PRESENCE_WAIT;
      tick_cfg[REG_RESET_RECOV] = RST_RESET_RECOV;
      tick_cfg[REG_SHORT_LOW] = RST_SHORT_LOW;
      tick_cfg[REG_LONG_LOW] = RST_LONG_LOW;
      tick_cfg[REG_ZERO_RECOV] = RST_ZERO_RECOV;
      tick_cfg[REG_READ_SAMPLE] = RST_READ_SAMPLE;
      tick_cfg[REG_READ_RECOV] = RST_READ_RECOV;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed ticks with every register at zero.
      for (int i = 0; i < CFG_COUNT; i++) vals[i] = '0;
      load_timing(vals);
      foreach (dir_rows[i]) begin
         for (int k = 0; k < dir_rows[i].reps; k++) begin
            push_tick(dir_rows[i].cv, dir_rows[i].cmd, dir_rows[i].wd, dir_rows[i].line,
                      dir_rows[i].typed && dir_rows[i].reps == 1, dir_rows[i].want);
         end
      end
      drain_all();

      // Short random timing under each idling pattern; the first starts with a hold-off.
      load_random_timing(0, 7);
      run_ops(5, 0, 0, 1'b1);
      load_random_timing(0, 7);
      run_ops(5, 72, 0, 1'b0);
      load_random_timing(0, 7);
      run_ops(5, 0, 72, 1'b0);
      load_random_timing(0, 7);
      run_ops(5, 32, 32, 1'b0);

      // Wider spread of tick counts, then short ones again.
      load_random_timing(0, 15);
      run_ops(2, 32, 32, 1'b0);
      load_random_timing(1, 5);
      run_ops(2, 0, 0, 1'b0);

      mismatches += rsp_owed.size();
      $display("Run covered %0d ticks under %0d timing settings:", tick_total, settings_used);
      $display("%0d bus resets, %0d writes, %0d reads, with sender gaps and receiver stalls.",
               ops_started[CMD_RESET], ops_started[CMD_WRITE], ops_started[CMD_READ]);
      $display("Response mismatches: %0d", mismatches);
      if (mismatches == 0) begin
         $display("[onewire_bus_master_top] OK");
      end else begin
         $display("[onewire_bus_master_top] ERROR");
      end
      $finish;
   end

endmodule
